>>> hdl/gosm_pkg.sv
// ----------------------------------------------------------------------------
// gosm_pkg
// Shared types, constants and helper functions of the gyro space mapper.
// ----------------------------------------------------------------------------
package gosm_pkg;

    // fixed-point formats
    localparam int QFB       = 14;
    localparam int RFB       = 8;
    localparam int SFB       = 24;
    localparam int SCR_SHIFT = SFB - RFB;

    // datapath widths
    localparam int ACC_W  = 68;
    localparam int MUL_W  = 34;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 32;
    localparam int ROOT_W = 32;
    localparam int CFG_W  = 8;

    // operating modes
    localparam logic [2:0] MODE_YAW       = 3'd0;
    localparam logic [2:0] MODE_ROLL      = 3'd1;
    localparam logic [2:0] MODE_YAW_ROLL  = 3'd2;
    localparam logic [2:0] MODE_LOCAL     = 3'd3;
    localparam logic [2:0] MODE_PLAYER    = 3'd4;
    localparam logic [2:0] MODE_WORLD     = 3'd5;
    localparam logic [2:0] MODE_LASER     = 3'd6;
    localparam logic [2:0] MODE_WORLD_YAW = 3'd7;

    // register indexes
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_HSEL = 1'b1;

    // arithmetic constants
    localparam logic signed [ACC_W-1:0] ACC_ONE    = 68'sd1 <<< (2 * QFB);
    localparam logic [ROOT_W-1:0]       WORLD_THR  = ROOT_W'(((1 << QFB) + 500) / 1000);
    localparam logic signed [31:0]      LASER_THR  = 32'(((1 << QFB) + 5) / 10);
    localparam logic signed [MUL_W-1:0] K_SCALE    = 34'sd57295800;
    localparam logic signed [MUL_W-1:0] K_FIXED    = 34'sd28600;
    localparam logic [15:0]             PERIOD_MIN = 16'd10;

    typedef struct packed {
        logic               active;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [23:0] gyro_x;
        logic signed [23:0] gyro_y;
        logic signed [23:0] gyro_z;
        logic [15:0]        period_us;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] x_rate;
        logic signed [31:0] y_rate;
    } t_out_word;

    // one rotation-matrix entry: base + 2*(+-a*b +-c*d)
    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] ic;
        logic [1:0] id;
        logic       n1;
        logic       n2;
        logic       diag;
    } t_mat_op;

    // one term of conj(ref) * q
    typedef struct packed {
        logic [1:0] idx;
        logic       neg;
    } t_lq_op;

    function automatic t_mat_op mat_op(input logic [3:0] e);
        t_mat_op o;
        case (e)
            4'd0:    o = '{2'd2, 2'd2, 2'd3, 2'd3, 1'b1, 1'b1, 1'b1};
            4'd1:    o = '{2'd1, 2'd2, 2'd0, 2'd3, 1'b0, 1'b1, 1'b0};
            4'd2:    o = '{2'd1, 2'd3, 2'd0, 2'd2, 1'b0, 1'b0, 1'b0};
            4'd3:    o = '{2'd1, 2'd2, 2'd0, 2'd3, 1'b0, 1'b0, 1'b0};
            4'd4:    o = '{2'd1, 2'd1, 2'd3, 2'd3, 1'b1, 1'b1, 1'b1};
            4'd5:    o = '{2'd2, 2'd3, 2'd0, 2'd1, 1'b0, 1'b1, 1'b0};
            4'd6:    o = '{2'd1, 2'd3, 2'd0, 2'd2, 1'b0, 1'b1, 1'b0};
            4'd7:    o = '{2'd2, 2'd3, 2'd0, 2'd1, 1'b0, 1'b0, 1'b0};
            4'd8:    o = '{2'd1, 2'd1, 2'd2, 2'd2, 1'b1, 1'b1, 1'b1};
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic t_lq_op lq_op(input logic [1:0] i, input logic [1:0] j);
        t_lq_op o;
        case ({i, j})
            4'h0: o = '{2'd0, 1'b0};
            4'h1: o = '{2'd1, 1'b0};
            4'h2: o = '{2'd2, 1'b0};
            4'h3: o = '{2'd3, 1'b0};
            4'h4: o = '{2'd1, 1'b0};
            4'h5: o = '{2'd0, 1'b1};
            4'h6: o = '{2'd3, 1'b1};
            4'h7: o = '{2'd2, 1'b0};
            4'h8: o = '{2'd2, 1'b0};
            4'h9: o = '{2'd3, 1'b0};
            4'ha: o = '{2'd0, 1'b1};
            4'hb: o = '{2'd1, 1'b1};
            4'hc: o = '{2'd3, 1'b0};
            4'hd: o = '{2'd2, 1'b1};
            4'he: o = '{2'd1, 1'b0};
            4'hf: o = '{2'd0, 1'b1};
            default: o = '0;
        endcase
        return o;
    endfunction

    // right shift, rounding half away from zero
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             s
    );
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m = (m + (68'd1 << (s - 1))) >> s;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = 32'(v);
        return r;
    endfunction

endpackage

>>> hdl/gosm_div.sv
// ----------------------------------------------------------------------------
// gosm_div
// Iterative signed divider, one quotient bit per cycle, rounds half away
// from zero. Divisor is positive.
// ----------------------------------------------------------------------------
module gosm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  logic signed [gosm_pkg::NUM_W-1:0] i_num,
    input  logic [gosm_pkg::DEN_W-1:0]      i_den,
    output logic                            o_done,
    output logic signed [gosm_pkg::NUM_W-1:0] o_quot
);
    import gosm_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [NUM_W-1:0] n_mag;
    logic [DEN_W:0]   n_rem_sh;
    logic             n_bit;

    // magnitude plus half divisor, and one restoring step
    always_comb begin
        n_mag    = (i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num)) +
                   NUM_W'(i_den >> 1);
        n_rem_sh = {r_rem[DEN_W-1:0], r_dvd[NUM_W-1]};
        n_bit    = (n_rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= n_mag;
                r_den  <= i_den;
                r_neg  <= i_num[NUM_W-1];
            end else if (r_busy) begin
                r_rem  <= n_bit ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
                r_dvd  <= {r_dvd[NUM_W-2:0], n_bit};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_dvd) : $signed(r_dvd);

endmodule

>>> hdl/gosm_sqrt.sv
// ----------------------------------------------------------------------------
// gosm_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gosm_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [gosm_pkg::NUM_W-1:0]   i_val,
    output logic                         o_done,
    output logic [gosm_pkg::ROOT_W-1:0]  o_root
);
    import gosm_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [NUM_W-1:0] r_v;
    logic [NUM_W-1:0] r_r;
    logic [NUM_W-1:0] r_bit;
    logic [NUM_W-1:0] n_t;

    assign n_t = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_v >= n_t) begin
                    r_v <= r_v - n_t;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

>>> hdl/gyro_orientation_space_mapper.sv
// ----------------------------------------------------------------------------
// gyro_orientation_space_mapper
// Maps one orientation/gyro report to a 2-D aim rate in the selected space.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------
//   input   | i_valid / o_ready       | i_data (t_in_word)
//   output  | o_valid / i_ready       | o_data (t_out_word)
//   config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Work per word, from acceptance until ready again: raw modes go straight to
// the output step, player modes build the matrix, world-yaw adds the rate
// vector, world adds a root and a divide (no divide when the projected
// right axis is near zero), laser adds up to four divides; a rising active
// edge adds the reference capture (no divides for an all-zero quaternion).
// One multiplier serves every product. Reset is synchronous; no input word
// is taken while one is in work. A result waiting on o_valid does not stop
// the next word from being taken; it only holds the final step of that word.
// ----------------------------------------------------------------------------
module gyro_orientation_space_mapper (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  gosm_pkg::t_in_word     i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output gosm_pkg::t_out_word    o_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [gosm_pkg::CFG_W-1:0] i_cfg_data
);
    import gosm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CAP_N2, S_CAP_SQRT, S_CAP_DIV, S_DISPATCH, S_LQ, S_MAT,
        S_PLAYER, S_OM, S_WAX, S_WSQRT, S_WDOT, S_WDIV, S_LASER, S_LSX,
        S_LSY, S_LDELTA, S_LMX, S_LDX, S_LMY, S_LDY, S_DONE
    } t_state;

    t_state                   r_state;
    logic [2:0]               r_mode;
    logic                     r_hsel;
    logic signed [15:0]       r_q [4];
    logic signed [23:0]       r_g [3];
    logic [15:0]              r_period;
    logic                     r_prev_act;
    logic signed [16:0]       r_ref [4];
    logic                     r_ref_valid;
    logic signed [19:0]       r_p [4];
    logic signed [31:0]       r_m [9];
    logic signed [31:0]       r_om [3];
    logic signed [ACC_W-1:0]  r_acc;
    logic [4:0]               r_k;
    logic [1:0]               r_i;
    logic [1:0]               r_j;
    logic                     r_div_go;
    logic signed [NUM_W-1:0]  r_div_num;
    logic [DEN_W-1:0]         r_div_den;
    logic                     r_sqrt_go;
    logic [NUM_W-1:0]         r_sqrt_val;
    logic [ROOT_W-1:0]        r_al;
    logic signed [31:0]       r_sx;
    logic signed [31:0]       r_sy;
    logic signed [31:0]       r_last_x;
    logic signed [31:0]       r_last_y;
    logic                     r_last_valid;
    logic signed [32:0]       r_dx;
    logic signed [32:0]       r_dy;
    logic signed [NUM_W-1:0]  r_x;
    logic signed [NUM_W-1:0]  r_y;
    t_out_word                r_out;
    logic                     r_ovalid;

    logic                     div_done;
    logic signed [NUM_W-1:0]  div_quot;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_neg;
    logic                     mul_dbl;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  n_rs;
    t_mat_op                  mop;
    t_lq_op                   lop;
    logic [3:0]               om_idx;
    logic                     rise;
    logic                     long_period;

    assign mop         = mat_op(r_k[4:1]);
    assign lop         = lq_op(r_i, r_j);
    assign om_idx      = 4'(r_i) * 4'd3 + 4'(r_j);
    assign rise        = i_data.active & ~r_prev_act;
    assign long_period = (r_period > PERIOD_MIN);

    // shared multiply-accumulate: operand selection per step
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        mul_neg  = 1'b0;
        mul_dbl  = 1'b0;
        acc_base = r_acc;
        case (r_state)
            S_CAP_N2: begin
                mul_a = MUL_W'(r_q[r_j]);
                mul_b = MUL_W'(r_q[r_j]);
                if (r_j == 2'd0) acc_base = '0;
            end
            S_MAT: begin
                mul_dbl = 1'b1;
                if (r_k[0]) begin
                    mul_a   = MUL_W'(r_p[mop.ic]);
                    mul_b   = MUL_W'(r_p[mop.id]);
                    mul_neg = mop.n2;
                end else begin
                    mul_a    = MUL_W'(r_p[mop.ia]);
                    mul_b    = MUL_W'(r_p[mop.ib]);
                    mul_neg  = mop.n1;
                    acc_base = mop.diag ? ACC_ONE : '0;
                end
            end
            S_OM: begin
                mul_a = MUL_W'(r_m[om_idx]);
                mul_b = MUL_W'(r_g[r_j]);
                if (r_j == 2'd0) acc_base = '0;
            end
            S_PLAYER: begin
                if (r_j == 2'd0) begin
                    mul_a    = MUL_W'(r_m[5]);
                    mul_b    = MUL_W'(r_g[2]);
                    acc_base = '0;
                end else begin
                    mul_a = MUL_W'(r_m[4]);
                    mul_b = MUL_W'(r_g[1]);
                end
            end
            S_WAX: begin
                if (r_j == 2'd0) begin
                    mul_a    = MUL_W'(r_m[0]);
                    mul_b    = MUL_W'(r_m[0]);
                    acc_base = '0;
                end else begin
                    mul_a = MUL_W'(r_m[6]);
                    mul_b = MUL_W'(r_m[6]);
                end
            end
            S_WDOT: begin
                if (r_j == 2'd0) begin
                    mul_a    = MUL_W'(r_om[0]);
                    mul_b    = MUL_W'(r_m[0]);
                    acc_base = '0;
                end else begin
                    mul_a = MUL_W'(r_om[2]);
                    mul_b = MUL_W'(r_m[6]);
                end
            end
            S_LQ: begin
                mul_a   = MUL_W'(r_ref[r_j]);
                mul_b   = MUL_W'(r_q[lop.idx]);
                mul_neg = lop.neg;
                if (r_j == 2'd0) acc_base = '0;
            end
            S_LMX: begin
                mul_a    = MUL_W'(r_dx);
                mul_b    = long_period ? K_SCALE : K_FIXED;
                acc_base = '0;
            end
            S_LMY: begin
                mul_a    = MUL_W'(r_dy);
                mul_b    = long_period ? K_SCALE : K_FIXED;
                acc_base = '0;
            end
            default: begin
                acc_base = r_acc;
            end
        endcase
        prod  = mul_a * mul_b;
        term  = mul_dbl ? (prod <<< 1) : prod;
        term  = mul_neg ? -term : term;
        n_acc = acc_base + term;
        n_rs  = round_shift(n_acc, QFB);
    end

    // sequencer, state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_YAW;
            r_hsel       <= 1'b0;
            r_prev_act   <= 1'b0;
            r_ref[0]     <= 17'sd1 <<< QFB;
            r_ref[1]     <= '0;
            r_ref[2]     <= '0;
            r_ref[3]     <= '0;
            r_ref_valid  <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_valid <= 1'b0;
            r_ovalid     <= 1'b0;
            r_div_go     <= 1'b0;
            r_sqrt_go    <= 1'b0;
            r_k          <= '0;
            r_i          <= '0;
            r_j          <= '0;
        end else begin
            r_div_go  <= 1'b0;
            r_sqrt_go <= 1'b0;

            // configuration write
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MODE: r_mode <= i_cfg_data[2:0];
                    REG_HSEL: r_hsel <= i_cfg_data[0];
                    default:  r_mode <= r_mode;
                endcase
            end

            // output taken with no new word behind it
            if (r_ovalid && i_ready && (r_state != S_DONE)) r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_q[0]     <= i_data.quat_w;
                        r_q[1]     <= i_data.quat_x;
                        r_q[2]     <= i_data.quat_y;
                        r_q[3]     <= i_data.quat_z;
                        r_g[0]     <= i_data.gyro_x;
                        r_g[1]     <= i_data.gyro_y;
                        r_g[2]     <= i_data.gyro_z;
                        r_period   <= i_data.period_us;
                        r_prev_act <= i_data.active;
                        r_j        <= '0;
                        r_state    <= rise ? S_CAP_N2 : S_DISPATCH;
                    end
                end
                // reference capture: norm, root, four divisions (none if the root is zero)
                S_CAP_N2: begin
                    r_acc <= n_acc;
                    r_j   <= r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        r_sqrt_val <= NUM_W'(n_acc);
                        r_sqrt_go  <= 1'b1;
                        r_state    <= S_CAP_SQRT;
                    end
                end
                S_CAP_SQRT: begin
                    if (sqrt_done) begin
                        if (sqrt_root == '0) begin
                            r_ref[0]     <= 17'sd1 <<< QFB;
                            r_ref[1]     <= '0;
                            r_ref[2]     <= '0;
                            r_ref[3]     <= '0;
                            r_ref_valid  <= 1'b1;
                            r_last_x     <= '0;
                            r_last_y     <= '0;
                            r_last_valid <= 1'b0;
                            r_state      <= S_DISPATCH;
                        end else begin
                            r_div_den <= sqrt_root;
                            r_div_num <= NUM_W'(r_q[0]) <<< QFB;
                            r_div_go  <= 1'b1;
                            r_j       <= '0;
                            r_state   <= S_CAP_DIV;
                        end
                    end
                end
                S_CAP_DIV: begin
                    if (div_done) begin
                        r_ref[r_j] <= 17'(div_quot);
                        if (r_j == 2'd3) begin
                            r_ref_valid  <= 1'b1;
                            r_last_x     <= '0;
                            r_last_y     <= '0;
                            r_last_valid <= 1'b0;
                            r_state      <= S_DISPATCH;
                        end else begin
                            r_j       <= r_j + 2'd1;
                            r_div_num <= NUM_W'(r_q[2'(r_j + 2'd1)]) <<< QFB;
                            r_div_go  <= 1'b1;
                        end
                    end
                end
                // mode selection
                S_DISPATCH: begin
                    r_k <= '0;
                    r_i <= '0;
                    r_j <= '0;
                    for (int n = 0; n < 4; n++) r_p[n] <= 20'(r_q[n]);
                    case (r_mode)
                        MODE_YAW: begin
                            r_x     <= r_hsel ? -NUM_W'(r_g[1]) : -NUM_W'(r_g[2]);
                            r_y     <= NUM_W'(r_g[0]);
                            r_state <= S_DONE;
                        end
                        MODE_ROLL: begin
                            r_x     <= NUM_W'(r_g[1]);
                            r_y     <= NUM_W'(r_g[0]);
                            r_state <= S_DONE;
                        end
                        MODE_LOCAL: begin
                            r_x     <= -NUM_W'(r_g[2]);
                            r_y     <= NUM_W'(r_g[0]);
                            r_state <= S_DONE;
                        end
                        MODE_LASER: begin
                            r_state <= r_ref_valid ? S_LQ : S_MAT;
                        end
                        default: begin
                            r_state <= S_MAT;
                        end
                    endcase
                end
                // relative quaternion conj(ref) * q
                S_LQ: begin
                    r_acc <= n_acc;
                    if (r_j == 2'd3) begin
                        r_p[r_i] <= 20'(n_rs);
                        r_j      <= '0;
                        if (r_i == 2'd3) begin
                            r_k     <= '0;
                            r_state <= S_MAT;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                // rotation matrix, two products per entry
                S_MAT: begin
                    r_acc <= n_acc;
                    r_k   <= r_k + 5'd1;
                    if (r_k[0]) r_m[r_k[4:1]] <= 32'(n_rs);
                    if (r_k == 5'd17) begin
                        r_i <= '0;
                        r_j <= '0;
                        case (r_mode)
                            MODE_LASER:                 r_state <= S_LASER;
                            MODE_YAW_ROLL, MODE_PLAYER: r_state <= S_PLAYER;
                            default:                    r_state <= S_OM;
                        endcase
                    end
                end
                S_PLAYER: begin
                    r_acc <= n_acc;
                    r_j   <= r_j + 2'd1;
                    if (r_j == 2'd1) begin
                        r_x     <= -NUM_W'(n_rs);
                        r_y     <= NUM_W'(r_g[0]);
                        r_state <= S_DONE;
                    end
                end
                // world-frame rate vector
                S_OM: begin
                    r_acc <= n_acc;
                    if (r_j == 2'd2) begin
                        r_om[r_i] <= 32'(n_rs);
                        r_j       <= '0;
                        if (r_i == 2'd2) begin
                            r_x <= -NUM_W'(r_om[1]);
                            r_y <= '0;
                            r_state <= (r_mode == MODE_WORLD) ? S_WAX : S_DONE;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                // world mode: projected right axis length and pitch rate
                S_WAX: begin
                    r_acc <= n_acc;
                    if (r_j == 2'd1) begin
                        r_sqrt_val <= NUM_W'(n_acc);
                        r_sqrt_go  <= 1'b1;
                        r_j        <= '0;
                        r_state    <= S_WSQRT;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_WSQRT: begin
                    if (sqrt_done) begin
                        r_al    <= sqrt_root;
                        r_state <= (sqrt_root > WORLD_THR) ? S_WDOT : S_DONE;
                    end
                end
                S_WDOT: begin
                    r_acc <= n_acc;
                    r_j   <= r_j + 2'd1;
                    if (r_j == 2'd1) begin
                        r_div_num <= NUM_W'(n_acc);
                        r_div_den <= r_al;
                        r_div_go  <= 1'b1;
                        r_state   <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_y     <= div_quot;
                        r_state <= S_DONE;
                    end
                end
                // laser pointer: screen point, delta, scale
                S_LASER: begin
                    if (r_m[4] <= LASER_THR) begin
                        r_x          <= '0;
                        r_y          <= '0;
                        r_last_valid <= 1'b0;
                        r_state      <= S_DONE;
                    end else begin
                        r_div_num <= NUM_W'(r_m[1]) <<< SFB;
                        r_div_den <= DEN_W'(r_m[4]);
                        r_div_go  <= 1'b1;
                        r_state   <= S_LSX;
                    end
                end
                S_LSX: begin
                    if (div_done) begin
                        r_sx      <= sat32(div_quot);
                        r_div_num <= NUM_W'(r_m[7]) <<< SFB;
                        r_div_go  <= 1'b1;
                        r_state   <= S_LSY;
                    end
                end
                S_LSY: begin
                    if (div_done) begin
                        r_sy    <= sat32(div_quot);
                        r_state <= S_LDELTA;
                    end
                end
                S_LDELTA: begin
                    r_dx         <= r_last_valid ? (33'(r_sx) - 33'(r_last_x)) : '0;
                    r_dy         <= r_last_valid ? (33'(r_sy) - 33'(r_last_y)) : '0;
                    r_last_x     <= r_sx;
                    r_last_y     <= r_sy;
                    r_last_valid <= 1'b1;
                    r_state      <= S_LMX;
                end
                S_LMX: begin
                    if (long_period) begin
                        r_div_num <= NUM_W'(n_acc);
                        r_div_den <= {r_period, 16'd0};
                        r_div_go  <= 1'b1;
                        r_state   <= S_LDX;
                    end else begin
                        r_x     <= NUM_W'(round_shift(n_acc, SCR_SHIFT));
                        r_state <= S_LMY;
                    end
                end
                S_LDX: begin
                    if (div_done) begin
                        r_x     <= div_quot;
                        r_state <= S_LMY;
                    end
                end
                S_LMY: begin
                    if (long_period) begin
                        r_div_num <= NUM_W'(n_acc);
                        r_div_den <= {r_period, 16'd0};
                        r_div_go  <= 1'b1;
                        r_state   <= S_LDY;
                    end else begin
                        r_y     <= NUM_W'(round_shift(n_acc, SCR_SHIFT));
                        r_state <= S_DONE;
                    end
                end
                S_LDY: begin
                    if (div_done) begin
                        r_y     <= div_quot;
                        r_state <= S_DONE;
                    end
                end
                // hand the word to the output register
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_out.x_rate <= sat32(r_x);
                        r_out.y_rate <= sat32(r_y);
                        r_ovalid     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gosm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    gosm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_sqrt_go),
        .i_val   (r_sqrt_val),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // checks
    a_one_unit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_div_go && r_sqrt_go))
        else $error("divider and root unit started together");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after a word was taken");

    a_point_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LDELTA) |=> r_last_valid)
        else $error("screen point not marked valid after delta");

endmodule
